// ===== rtl/core/gradient_hysteresis_edges_core_macros.svh =====
// assertion helpers, each expects i_clk and i_rst_n in scope
`ifndef GRADIENT_HYSTERESIS_EDGES_CORE_MACROS_SVH
`define GRADIENT_HYSTERESIS_EDGES_CORE_MACROS_SVH

`define GHE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

`define GHE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ghe_pkg.sv =====
package ghe_pkg;

    localparam int PIX_BITS      = 8;
    localparam int LVL_BITS      = 9;
    localparam int DIFF_BITS     = 9;
    localparam int SQ_BITS       = 16;
    localparam int G2_BITS       = 17;
    localparam int LVL_SQ_BITS   = 18;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;
    localparam int MIN_SIZE      = 3;
    localparam int RST_LOW       = 50;
    localparam int RST_HIGH      = 100;
    localparam int RST_WIDTH     = 640;
    localparam int RST_HEIGHT    = 480;

    localparam int Q_DEPTH    = 4;
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        LAB_NONE   = 2'd0,
        LAB_WEAK   = 2'd1,
        LAB_STRONG = 2'd2
    } t_label;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LOW    = 2'd0,
        REG_HIGH   = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } t_reg;

    // one step of the back end: first label of a pixel plus where the settled pixel sits
    typedef struct packed {
        t_label label;
        logic   settle;
        logic   last;
        logic   top;
        logic   bot;
        logic   lft;
        logic   rgt;
    } t_step;

endpackage

// ===== rtl/core/ghe_pix_if.sv =====
interface ghe_pix_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] intensity;

    modport source (output valid, output kind, output intensity, input ready);
    modport sink (input valid, input kind, input intensity, output ready);
endinterface

// ===== rtl/core/ghe_res_if.sv =====
interface ghe_res_if;
    logic valid;
    logic ready;
    logic is_edge;
    logic frame_end;

    modport source (output valid, output is_edge, output frame_end, input ready);
    modport sink (input valid, input is_edge, input frame_end, output ready);
endinterface

// ===== rtl/core/ghe_queue.sv =====
`include "gradient_hysteresis_edges_core_macros.svh"

module ghe_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  ghe_pkg::t_step                  i_push_data,
    input  logic                            i_pop,
    output logic                            o_valid,
    output ghe_pkg::t_step                  o_data,
    output logic [ghe_pkg::Q_CNT_BITS-1:0]  o_count
);

    ghe_pkg::t_step                  r_mem [ghe_pkg::Q_DEPTH];
    logic [ghe_pkg::Q_PTR_BITS-1:0]  r_wp;
    logic [ghe_pkg::Q_PTR_BITS-1:0]  r_rp;
    logic [ghe_pkg::Q_CNT_BITS-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;

    `GHE_ASSERT_IMPLIES(a_q_no_overflow, i_push && !i_pop, r_count < ghe_pkg::Q_CNT_BITS'(ghe_pkg::Q_DEPTH), "queue overflow")
    `GHE_ASSERT_IMPLIES(a_q_no_underflow, i_pop, r_count != '0, "queue underflow")

endmodule

// ===== rtl/core/ghe_front.sv =====
`include "gradient_hysteresis_edges_core_macros.svh"

module ghe_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ghe_pix_if.sink                           i_pix,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    i_w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]   i_h,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+2*MAX_WIDTH+2)-1:0] i_total,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+2*MAX_WIDTH+2)-1:0] i_cend,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+2*MAX_WIDTH+2)-1:0] i_lag,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+2*MAX_WIDTH+2)-1:0] i_tlast,
    input  logic [ghe_pkg::LVL_SQ_BITS-1:0]   i_lo_sq,
    input  logic [ghe_pkg::LVL_SQ_BITS-1:0]   i_hi_sq,
    input  logic                              i_restart,
    input  logic [ghe_pkg::Q_CNT_BITS-1:0]    i_q_count,
    output logic                              o_push,
    output ghe_pkg::t_step                    o_push_data
);

    localparam int W_BITS = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS = $clog2(MAX_HEIGHT + 1);
    localparam int T_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2);
    localparam int A_BITS = $clog2(MAX_WIDTH);
    localparam int C_BITS = ghe_pkg::Q_CNT_BITS + 1;

    // step counter and positions of the classified and the settled pixel
    logic [T_BITS-1:0] r_t;
    logic [W_BITS-1:0] r_ccol;
    logic [H_BITS-1:0] r_crow;
    logic [W_BITS-1:0] r_ocol;
    logic [H_BITS-1:0] r_orow;
    logic [A_BITS-1:0] r_p1;
    logic [A_BITS-1:0] r_p2;

    logic [ghe_pkg::PIX_BITS-1:0] r_pmem1 [MAX_WIDTH];
    logic [ghe_pkg::PIX_BITS-1:0] r_pmem2 [MAX_WIDTH];
    logic [ghe_pkg::PIX_BITS-1:0] r_rd1;
    logic [ghe_pkg::PIX_BITS-1:0] r_rd2;
    logic [ghe_pkg::PIX_BITS-1:0] r_q1;
    logic [ghe_pkg::PIX_BITS-1:0] r_q2;

    logic                                r_s1_v;
    logic signed [ghe_pkg::DIFF_BITS-1:0] r_s1_dv;
    logic signed [ghe_pkg::DIFF_BITS-1:0] r_s1_dh;
    ghe_pkg::t_step                      r_s1_step;
    logic                                r_s2_v;
    logic [ghe_pkg::SQ_BITS-1:0]         r_s2_sqv;
    logic [ghe_pkg::SQ_BITS-1:0]         r_s2_sqh;
    ghe_pkg::t_step                      r_s2_step;

    logic                                 ignore;
    logic                                 step;
    logic                                 cls;
    logic                                 settle;
    logic                                 last;
    logic                                 interior;
    logic signed [ghe_pkg::DIFF_BITS-1:0] dv;
    logic signed [ghe_pkg::DIFF_BITS-1:0] dh;
    logic signed [2*ghe_pkg::DIFF_BITS-1:0] pv;
    logic signed [2*ghe_pkg::DIFF_BITS-1:0] ph;
    logic [ghe_pkg::G2_BITS-1:0]          g2;
    logic [C_BITS-1:0]                    in_flight;
    ghe_pkg::t_step                       step_info;

    assign in_flight = C_BITS'(i_q_count) + C_BITS'(r_s1_v) + C_BITS'(r_s2_v);
    assign i_pix.ready = (in_flight < C_BITS'(ghe_pkg::Q_DEPTH));

    // a drain item before the last pixel does nothing
    assign ignore = (r_t < i_total) && i_pix.kind;
    assign step   = i_pix.valid && i_pix.ready && !ignore;
    assign cls    = (r_t >= T_BITS'(i_w)) && (r_t < i_cend);
    assign settle = (r_t >= i_lag);
    assign last   = settle && (r_t == i_tlast);

    assign interior = cls && (r_crow != '0) && (r_crow <= i_h - H_BITS'(2))
                      && (r_ccol != '0) && (r_ccol <= i_w - W_BITS'(2));

    always_comb begin
        dv = '0;
        dh = '0;
        if (interior) begin
            dv = $signed({1'b0, i_pix.intensity}) - $signed({1'b0, r_rd2});
            dh = $signed({1'b0, r_rd1}) - $signed({1'b0, r_q2});
        end
    end

    always_comb begin
        step_info        = '0;
        step_info.label  = ghe_pkg::LAB_NONE;
        step_info.settle = settle;
        step_info.last   = last;
        step_info.top    = (r_orow == '0);
        step_info.bot    = (r_orow == i_h - H_BITS'(1));
        step_info.lft    = (r_ocol == '0);
        step_info.rgt    = (r_ocol == i_w - W_BITS'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_t    <= '0;
            r_ccol <= '0;
            r_crow <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_p1   <= '0;
            r_p2   <= '0;
        end else if (step) begin
            if (last) begin
                r_t    <= '0;
                r_ccol <= '0;
                r_crow <= '0;
                r_ocol <= '0;
                r_orow <= '0;
            end else begin
                r_t <= r_t + T_BITS'(1);
                if (cls) begin
                    if (r_ccol == i_w - W_BITS'(1)) begin
                        r_ccol <= '0;
                        r_crow <= r_crow + H_BITS'(1);
                    end else begin
                        r_ccol <= r_ccol + W_BITS'(1);
                    end
                end
                if (settle) begin
                    if (r_ocol == i_w - W_BITS'(1)) begin
                        r_ocol <= '0;
                        r_orow <= r_orow + H_BITS'(1);
                    end else begin
                        r_ocol <= r_ocol + W_BITS'(1);
                    end
                end
            end
            // delay of w-1 steps through the first line, w+1 more through the second
            if (W_BITS'(r_p1) == i_w - W_BITS'(3)) begin
                r_p1 <= '0;
            end else begin
                r_p1 <= r_p1 + A_BITS'(1);
            end
            if (W_BITS'(r_p2) == i_w - W_BITS'(1)) begin
                r_p2 <= '0;
            end else begin
                r_p2 <= r_p2 + A_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_rd1          <= r_pmem1[r_p1];
            r_pmem1[r_p1]  <= i_pix.intensity;
            r_rd2          <= r_pmem2[r_p2];
            r_pmem2[r_p2]  <= r_rd1;
            r_q1           <= r_rd1;
            r_q2           <= r_q1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= step;
            r_s2_v <= r_s1_v;
        end
    end

    assign pv = r_s1_dv * r_s1_dv;
    assign ph = r_s1_dh * r_s1_dh;

    always_ff @(posedge i_clk) begin
        r_s1_dv   <= dv;
        r_s1_dh   <= dh;
        r_s1_step <= step_info;
        r_s2_sqv  <= pv[ghe_pkg::SQ_BITS-1:0];
        r_s2_sqh  <= ph[ghe_pkg::SQ_BITS-1:0];
        r_s2_step <= r_s1_step;
    end

    assign g2 = ghe_pkg::G2_BITS'(r_s2_sqv) + ghe_pkg::G2_BITS'(r_s2_sqh);

    always_comb begin
        o_push_data = r_s2_step;
        if (ghe_pkg::LVL_SQ_BITS'(g2) > i_hi_sq) begin
            o_push_data.label = ghe_pkg::LAB_STRONG;
        end else if (ghe_pkg::LVL_SQ_BITS'(g2) < i_lo_sq) begin
            o_push_data.label = ghe_pkg::LAB_NONE;
        end else begin
            o_push_data.label = ghe_pkg::LAB_WEAK;
        end
    end

    assign o_push = r_s2_v;

    `GHE_ASSERT_ALWAYS(a_credit, in_flight <= C_BITS'(ghe_pkg::Q_DEPTH), "queue credit exceeded")

endmodule

// ===== rtl/core/ghe_back.sv =====
module ghe_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]  i_w,
    input  logic                            i_restart,
    input  logic                            i_q_valid,
    input  ghe_pkg::t_step                  i_q_data,
    output logic                            o_pop,
    ghe_res_if.source                       o_res
);

    localparam int W_BITS = $clog2(MAX_WIDTH + 1);
    localparam int A_BITS = $clog2(MAX_WIDTH);

    ghe_pkg::t_label r_fmem [MAX_WIDTH];
    ghe_pkg::t_label r_umem [MAX_WIDTH];
    logic [A_BITS-1:0] r_fp;
    logic [A_BITS-1:0] r_up;

    // 3x3 window: u row above (final), f/fprev own row, c row below (first labels)
    ghe_pkg::t_label r_frd;
    ghe_pkg::t_label r_f1;
    ghe_pkg::t_label r_fprev;
    ghe_pkg::t_label r_urd;
    ghe_pkg::t_label r_u1;
    ghe_pkg::t_label r_u2;
    ghe_pkg::t_label r_c1;
    ghe_pkg::t_label r_c2;
    ghe_pkg::t_label r_c3;

    logic r_ov;
    logic r_edge;
    logic r_end;

    ghe_pkg::t_step  hd;
    logic            strong_any;
    ghe_pkg::t_label fin;

    assign hd    = i_q_data;
    assign o_pop = i_q_valid && (!r_ov || o_res.ready);

    assign strong_any =
        (!hd.top && !hd.lft && r_u2 == ghe_pkg::LAB_STRONG) ||
        (!hd.top && r_u1 == ghe_pkg::LAB_STRONG) ||
        (!hd.top && !hd.rgt && r_urd == ghe_pkg::LAB_STRONG) ||
        (!hd.lft && r_fprev == ghe_pkg::LAB_STRONG) ||
        (!hd.rgt && r_frd == ghe_pkg::LAB_STRONG) ||
        (!hd.bot && !hd.lft && r_c3 == ghe_pkg::LAB_STRONG) ||
        (!hd.bot && r_c2 == ghe_pkg::LAB_STRONG) ||
        (!hd.bot && !hd.rgt && r_c1 == ghe_pkg::LAB_STRONG);

    always_comb begin
        fin = r_f1;
        if (r_f1 == ghe_pkg::LAB_WEAK) begin
            fin = strong_any ? ghe_pkg::LAB_STRONG : ghe_pkg::LAB_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_fp <= '0;
            r_up <= '0;
        end else if (o_pop) begin
            if (W_BITS'(r_fp) == i_w - W_BITS'(1)) begin
                r_fp <= '0;
            end else begin
                r_fp <= r_fp + A_BITS'(1);
            end
            if (W_BITS'(r_up) == i_w - W_BITS'(3)) begin
                r_up <= '0;
            end else begin
                r_up <= r_up + A_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_frd        <= r_fmem[r_fp];
            r_fmem[r_fp] <= hd.label;
            r_f1         <= r_frd;
            r_urd        <= r_umem[r_up];
            r_umem[r_up] <= fin;
            r_u1         <= r_urd;
            r_u2         <= r_u1;
            r_c1         <= hd.label;
            r_c2         <= r_c1;
            r_c3         <= r_c2;
            r_fprev      <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_pop && hd.settle) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && hd.settle) begin
            r_edge <= (fin == ghe_pkg::LAB_STRONG);
            r_end  <= hd.last;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.is_edge   = r_edge;
    assign o_res.frame_end = r_end;

endmodule

// ===== rtl/core/gradient_hysteresis_edges_core.sv =====
// channel   dir  beat payload          accepted when
// i_pix     in   kind, intensity       valid & ready
// o_res     out  is_edge, frame_end    valid & ready
// i_cfg_*   in   idx, data             i_cfg_we
//
// one item per cycle sustained while o_res is ready; the result of the k-th item of a frame leaves with item k+2W+2
// result valid rises once its item has passed the 2 front stages, the queue and the out reg
// synchronous active-low reset; line stores are not cleared, every entry is written before use
// front stalls only on queue credit (depth 4), back stalls only on the output register
// a frame size write restarts the frame; derived sizes follow any write through r_total, then r_cend and r_tlast
module gradient_hysteresis_edges_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ghe_pix_if.sink                            i_pix,
    ghe_res_if.source                          o_res,
    input  logic                               i_cfg_we,
    input  logic [ghe_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [ghe_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int W_BITS = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS = $clog2(MAX_HEIGHT + 1);
    localparam int T_BITS = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 2);
    localparam int RST_W  = (MAX_WIDTH < ghe_pkg::RST_WIDTH) ? MAX_WIDTH : ghe_pkg::RST_WIDTH;
    localparam int RST_H  = (MAX_HEIGHT < ghe_pkg::RST_HEIGHT) ? MAX_HEIGHT : ghe_pkg::RST_HEIGHT;
    localparam int RST_TOTAL = RST_W * RST_H;
    localparam int RST_LO_SQ = ghe_pkg::RST_LOW * ghe_pkg::RST_LOW;
    localparam int RST_HI_SQ = ghe_pkg::RST_HIGH * ghe_pkg::RST_HIGH;

    logic [ghe_pkg::LVL_BITS-1:0]    r_low;
    logic [ghe_pkg::LVL_BITS-1:0]    r_high;
    logic [W_BITS-1:0]               r_w;
    logic [H_BITS-1:0]               r_h;
    logic                            r_restart;
    logic [T_BITS-1:0]               r_total;
    logic [T_BITS-1:0]               r_cend;
    logic [T_BITS-1:0]               r_lag;
    logic [T_BITS-1:0]               r_tlast;
    logic [ghe_pkg::LVL_SQ_BITS-1:0] r_lo_sq;
    logic [ghe_pkg::LVL_SQ_BITS-1:0] r_hi_sq;

    logic                            push;
    ghe_pkg::t_step                  push_data;
    logic                            pop;
    logic                            q_valid;
    ghe_pkg::t_step                  q_data;
    logic [ghe_pkg::Q_CNT_BITS-1:0]  q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low     <= ghe_pkg::LVL_BITS'(ghe_pkg::RST_LOW);
            r_high    <= ghe_pkg::LVL_BITS'(ghe_pkg::RST_HIGH);
            r_w       <= W_BITS'(RST_W);
            r_h       <= H_BITS'(RST_H);
            r_restart <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (i_cfg_we) begin
                case (ghe_pkg::t_reg'(i_cfg_idx))
                    ghe_pkg::REG_LOW: begin
                        r_low <= i_cfg_data[ghe_pkg::LVL_BITS-1:0];
                    end
                    ghe_pkg::REG_HIGH: begin
                        r_high <= i_cfg_data[ghe_pkg::LVL_BITS-1:0];
                    end
                    ghe_pkg::REG_WIDTH: begin
                        r_restart <= 1'b1;
                        if (32'(i_cfg_data) < ghe_pkg::MIN_SIZE) begin
                            r_w <= W_BITS'(ghe_pkg::MIN_SIZE);
                        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
                            r_w <= W_BITS'(MAX_WIDTH);
                        end else begin
                            r_w <= W_BITS'(i_cfg_data);
                        end
                    end
                    ghe_pkg::REG_HEIGHT: begin
                        r_restart <= 1'b1;
                        if (32'(i_cfg_data) < ghe_pkg::MIN_SIZE) begin
                            r_h <= H_BITS'(ghe_pkg::MIN_SIZE);
                        end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
                            r_h <= H_BITS'(MAX_HEIGHT);
                        end else begin
                            r_h <= H_BITS'(i_cfg_data);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // frame sizes and squared thresholds, one multiply per register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= T_BITS'(RST_TOTAL);
            r_lag   <= T_BITS'(2 * RST_W + 2);
            r_cend  <= T_BITS'(RST_TOTAL + RST_W);
            r_tlast <= T_BITS'(RST_TOTAL + 2 * RST_W + 1);
            r_lo_sq <= ghe_pkg::LVL_SQ_BITS'(RST_LO_SQ);
            r_hi_sq <= ghe_pkg::LVL_SQ_BITS'(RST_HI_SQ);
        end else begin
            r_total <= T_BITS'(r_w) * T_BITS'(r_h);
            r_lag   <= T_BITS'({r_w, 1'b0}) + T_BITS'(2);
            r_cend  <= r_total + T_BITS'(r_w);
            r_tlast <= r_total + T_BITS'({r_w, 1'b0}) + T_BITS'(1);
            r_lo_sq <= ghe_pkg::LVL_SQ_BITS'(r_low) * ghe_pkg::LVL_SQ_BITS'(r_low);
            r_hi_sq <= ghe_pkg::LVL_SQ_BITS'(r_high) * ghe_pkg::LVL_SQ_BITS'(r_high);
        end
    end

    ghe_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_w         (r_w),
        .i_h         (r_h),
        .i_total     (r_total),
        .i_cend      (r_cend),
        .i_lag       (r_lag),
        .i_tlast     (r_tlast),
        .i_lo_sq     (r_lo_sq),
        .i_hi_sq     (r_hi_sq),
        .i_restart   (r_restart),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_push_data (push_data)
    );

    ghe_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .o_count     (q_count)
    );

    ghe_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_w       (r_w),
        .i_restart (r_restart),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW = 1024;
    localparam int MAXH = 1024;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_SLACK = 12;
    localparam int BEAT_GOAL = 1800;

    typedef struct {
        bit is_edge;
        bit frame_end;
    } t_edge_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ghe_pkg::CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [ghe_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    ghe_pix_if pix_if ();
    ghe_res_if res_if ();

    gradient_hysteresis_edges_core #(
        .MAX_WIDTH (MAXW),
        .MAX_HEIGHT(MAXH)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix_if.sink),
        .o_res     (res_if.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // mirror of the block state
    logic [7:0]       pixel_rows [2*MAXW];
    ghe_pkg::t_label  label_rows [3*MAXW];
    int         col_in, row_in, beats_in_frame;
    int         lo_lvl, hi_lvl, wd, ht;

    t_edge_result edge_q[$];
    int  mismatches;
    int  cycles;
    int  beats_sent;
    bit  tx_steady, rx_steady, rx_hold;
    int  rx_wait;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int lab_at(int r, int c);
        return (r % 3) * MAXW + (c % MAXW);
    endfunction

    function automatic int pix_at(int r, int c);
        return (r % 2) * MAXW + (c % MAXW);
    endfunction

    function automatic ghe_pkg::t_label classify(int g2);
        if (g2 > hi_lvl * hi_lvl) return ghe_pkg::LAB_STRONG;
        if (g2 < lo_lvl * lo_lvl) return ghe_pkg::LAB_NONE;
        return ghe_pkg::LAB_WEAK;
    endfunction

    // weak pixel goes strong if any in-frame neighbor is strong
    function automatic ghe_pkg::t_label settle_label(int a, int b);
        ghe_pkg::t_label lab;
        int r, c;
        lab = label_rows[lab_at(a, b)];
        if (lab != ghe_pkg::LAB_WEAK) return lab;
        for (int da = -1; da <= 1; da++) begin
            for (int db = -1; db <= 1; db++) begin
                r = a + da;
                c = b + db;
                if (da == 0 && db == 0) continue;
                if (r < 0 || r >= ht || c < 0 || c >= wd) continue;
                if (label_rows[lab_at(r, c)] == ghe_pkg::LAB_STRONG) return ghe_pkg::LAB_STRONG;
            end
        end
        return ghe_pkg::LAB_NONE;
    endfunction

    function automatic void restart_frame();
        col_in = 0;
        row_in = 0;
        beats_in_frame = 0;
    endfunction

    function automatic void predict_edge(bit kind, logic [7:0] pix);
        int total, t, p, a, b, l, r, c, dv, dh, g2;
        bit last;
        ghe_pkg::t_label fin;
        t_edge_result res;
        total = wd * ht;
        t = beats_in_frame;
        last = 1'b0;
        if (t < total && kind) return;
        if (t >= 2 * wd + 2) begin
            p = t - (2 * wd + 2);
            a = p / wd;
            b = p % wd;
            fin = settle_label(a, b);
            label_rows[lab_at(a, b)] = fin;
            last = (p == total - 1);
            res.is_edge = (fin == ghe_pkg::LAB_STRONG);
            res.frame_end = last;
            edge_q.push_back(res);
        end
        if (t >= wd && t - wd < total) begin
            l = t - wd;
            r = l / wd;
            c = l % wd;
            g2 = 0;
            if (r >= 1 && r + 2 <= ht && c >= 1 && c + 2 <= wd) begin
                dv = int'(pix) - int'(pixel_rows[pix_at(r - 1, c)]);
                dh = int'(pixel_rows[pix_at(r, c + 1)]) - int'(pixel_rows[pix_at(r, c - 1)]);
                g2 = dv * dv + dh * dh;
            end
            label_rows[lab_at(r, c)] = classify(g2);
        end
        if (t < total) begin
            pixel_rows[pix_at(row_in, col_in)] = pix;
            col_in++;
            if (col_in >= wd) begin
                col_in = 0;
                row_in++;
            end
        end
        beats_in_frame = t + 1;
        if (last) restart_frame();
    endfunction

    // result side: random stalls, plus a long hold when asked
    always @(posedge i_clk) begin
        t_edge_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (edge_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end else begin
                    want = edge_q.pop_front();
                    if (res_if.is_edge !== want.is_edge) begin
                        $error("is_edge expected %0d actual %0d", want.is_edge, res_if.is_edge);
                        mismatches++;
                    end
                    if (res_if.frame_end !== want.frame_end) begin
                        $error("frame_end expected %0d actual %0d",
                               want.frame_end, res_if.frame_end);
                        mismatches++;
                    end
                end
                rx_wait = rx_steady ? 0 : $urandom_range(0, 4);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            res_if.ready <= (rx_wait == 0) && !rx_hold;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_beat(bit kind, logic [7:0] pix);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.kind <= kind;
        pix_if.intensity <= pix;
        do @(posedge i_clk); while (!pix_if.ready);
        beats_sent++;
        predict_edge(kind, pix);
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (edge_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic write_reg(ghe_pkg::t_reg idx, int value);
        int v;
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[ghe_pkg::CFG_DATA_BITS-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ghe_pkg::REG_LOW: lo_lvl = value & 'h1FF;
            ghe_pkg::REG_HIGH: hi_lvl = value & 'h1FF;
            ghe_pkg::REG_WIDTH: begin
                v = value & 'h7FF;
                wd = (v < ghe_pkg::MIN_SIZE) ? ghe_pkg::MIN_SIZE : (v > MAXW ? MAXW : v);
                restart_frame();
            end
            ghe_pkg::REG_HEIGHT: begin
                v = value & 'h7FF;
                ht = (v < ghe_pkg::MIN_SIZE) ? ghe_pkg::MIN_SIZE : (v > MAXH ? MAXH : v);
                restart_frame();
            end
            default: ;
        endcase
        // let the derived sizes settle
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_frame(int lo, int hi, int w, int h);
        write_reg(ghe_pkg::REG_LOW, lo);
        write_reg(ghe_pkg::REG_HIGH, hi);
        write_reg(ghe_pkg::REG_WIDTH, w);
        write_reg(ghe_pkg::REG_HEIGHT, h);
    endtask

    // two flat regions split at a given column, with some random texture
    task automatic send_pixels(int n, int step_col, int va, int vb, int grain, bit noisy);
        int c, v;
        for (int k = 0; k < n; k++) begin
            if (noisy && $urandom_range(0, 19) == 0) send_beat(1'b1, 8'($urandom));
            c = beats_in_frame % wd;
            v = (c < step_col ? va : vb) + $urandom_range(0, grain);
            send_beat(1'b0, (v > 255) ? 8'd255 : 8'(v));
        end
    endtask

    task automatic send_drains(int n, bit mixed);
        for (int k = 0; k < n; k++) begin
            // a pixel after the frame is complete flushes like a drain
            if (mixed && $urandom_range(0, 2) == 0) send_beat(1'b0, 8'($urandom));
            else send_beat(1'b1, 8'($urandom));
        end
    endtask

    task automatic random_frame(bit noisy);
        send_pixels(wd * ht, $urandom_range(0, wd), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 80), noisy);
        send_drains(2 * wd + 2, noisy);
    endtask

    task automatic test_threshold_extremes();
        set_frame(0, 0, 3, 3);
        for (int k = 0; k < 9; k++) send_beat(1'b0, (k % 2) ? 8'd255 : 8'd0);
        send_drains(8, 1'b0);
        wait_idle();
        set_frame(511, 511, 3, 3);
        send_pixels(9, 1, 0, 255, 0, 1'b0);
        send_drains(8, 1'b1);
        wait_idle();
    endtask

    task automatic test_drain_rules();
        set_frame(20, 60, 4, 3);
        send_beat(1'b1, 8'hFF);
        send_pixels(6, 2, 10, 200, 30, 1'b0);
        send_beat(1'b1, 8'h00);
        send_pixels(6, 1, 250, 5, 30, 1'b0);
        send_drains(10, 1'b1);
        wait_idle();
    endtask

    task automatic test_abort_and_midframe();
        set_frame(30, 90, 6, 5);
        send_pixels(17, 3, 0, 180, 40, 1'b0);
        wait_idle();
        write_reg(ghe_pkg::REG_LOW, 10);
        write_reg(ghe_pkg::REG_HIGH, 40);
        send_pixels(13, 2, 200, 20, 40, 1'b0);
        send_drains(14, 1'b0);
        wait_idle();
        send_pixels(20, 4, 0, 255, 10, 1'b0);
        wait_idle();
        write_reg(ghe_pkg::REG_WIDTH, 5);
        random_frame(1'b0);
        wait_idle();
    endtask

    task automatic test_size_extremes();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        // both sizes clamp up to the minimum
        set_frame(25, 70, 0, 1);
        random_frame(1'b0);
        wait_idle();
        // height clamps down to the maximum; part of a frame, then aborted
        set_frame(40, 120, 3, 2047);
        send_pixels(60, 1, 20, 200, 40, 1'b0);
        wait_idle();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    task automatic test_backpressure();
        set_frame(30, 80, 16, 6);
        tx_steady = 1'b1;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (300) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            random_frame(1'b0);
        join
        wait_idle();
        tx_steady = 1'b0;
    endtask

    task automatic test_random_frames();
        int lo;
        while (beats_sent < BEAT_GOAL) begin
            lo = $urandom_range(0, 120);
            set_frame(lo, lo + $urandom_range(0, 150), $urandom_range(3, 14),
                      $urandom_range(3, 10));
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 2)) begin
                random_frame($urandom_range(0, 3) == 0);
            end
            wait_idle();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        mismatches = 0;
        cycles = 0;
        beats_sent = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        rx_hold <= 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= ghe_pkg::REG_LOW;
        i_cfg_data <= '0;
        pix_if.valid <= 1'b0;
        pix_if.kind <= 1'b0;
        pix_if.intensity <= '0;
        lo_lvl = ghe_pkg::RST_LOW;
        hi_lvl = ghe_pkg::RST_HIGH;
        wd = ghe_pkg::RST_WIDTH;
        ht = ghe_pkg::RST_HEIGHT;
        restart_frame();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_threshold_extremes();
        test_drain_rules();
        test_abort_and_midframe();
        test_size_extremes();
        test_backpressure();
        test_random_frames();

        wait_idle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== gradient_hysteresis_edges_core.f =====
+incdir+rtl/core
rtl/core/ghe_pkg.sv
rtl/core/ghe_pix_if.sv
rtl/core/ghe_res_if.sv
rtl/core/ghe_queue.sv
rtl/core/ghe_front.sv
rtl/core/ghe_back.sv
rtl/core/gradient_hysteresis_edges_core.sv
tb/sv/tb_top.sv
